FILE: hw/rtl/bmsirq_pkg.sv
// Shared types and constants for the bank mapper with scanline interrupt.
// Holds command codes, configuration indexes and the remainder unit's
// request and status structs. No dependencies.
`timescale 1ns / 1ps

package bmsirq_pkg;

  // Bus operation codes
  localparam logic [2:0] CMD_CPU_RD = 3'd0;
  localparam logic [2:0] CMD_CPU_WR = 3'd1;
  localparam logic [2:0] CMD_PPU_RD = 3'd2;
  localparam logic [2:0] CMD_PPU_WR = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_COUNT   = 2'd0;
  localparam logic [1:0] CFG_CHR_IS_RAM  = 2'd1;
  localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;

  // 8K window codes from address bits 14:13 of a CPU access
  localparam logic [1:0] WIN_8000 = 2'd0;
  localparam logic [1:0] WIN_A000 = 2'd1;
  localparam logic [1:0] WIN_C000 = 2'd2;
  localparam logic [1:0] WIN_E000 = 2'd3;

  // Mirroring codes
  localparam logic [1:0] MIRROR_FOUR = 2'd2;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MaddrW = 21;
  localparam int unsigned NumBankRegs = 8;
  localparam logic [ByteW-1:0] MinBankCount = 8'd2;

  // Remainder unit request: one start pulse with operands
  typedef struct packed {
    logic             start;
    logic [ByteW-1:0] dividend;
    logic [ByteW-1:0] divisor;
  } bmsirq_mod_req_t;

  // Remainder unit status: done pulse with the remainder
  typedef struct packed {
    logic             done;
    logic [ByteW-1:0] rem;
  } bmsirq_mod_sts_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOD  = 3'b010,
    S_DONE = 3'b100
  } bmsirq_state_t;

endpackage

FILE: hw/rtl/bmsirq_modunit.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on bmsirq_pkg for operand width and request/status structs.
`timescale 1ns / 1ps

module bmsirq_modunit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bmsirq_pkg::bmsirq_mod_req_t req,
  output bmsirq_pkg::bmsirq_mod_sts_t sts
);
  import bmsirq_pkg::*;

  localparam int unsigned StepW = $clog2(ByteW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [ByteW-1:0] rem_r, rem_nxt;
  logic [ByteW-1:0] dvd_r, dvd_nxt;
  logic [ByteW-1:0] dvs_r, dvs_nxt;
  logic [ByteW:0]   trial;
  logic [ByteW:0]   diff;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial    = {rem_r, dvd_r[ByteW-1]};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = (trial >= {1'b0, dvs_r}) ? diff[ByteW-1:0] : trial[ByteW-1:0];
      dvd_nxt  = {dvd_r[ByteW-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == StepW'(ByteW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Advance operand registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.done = done_r;
  assign sts.rem  = rem_r;

endmodule

FILE: hw/rtl/bank_mapper_with_scanline_irq_core.sv
// Top level of the cartridge bank mapper with scanline interrupt counter.
// Depends on bmsirq_pkg and bmsirq_modunit (bank number remainder).
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | in_cmd, in_bus_addr, in_write_data
//   out     | output    | out_valid/out_ready | out_mapped, out_mapped_addr,
//           |           |                     | out_irq_line, out_mirror_mode,
//           |           |                     | out_ram_protect
//   cfg     | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// A CPU read at 0x8000-0xDFFF goes through S_MOD, where the shared remainder unit
// works out the bank number one bit per cycle, and then S_DONE, which loads its result;
// in_ready returns as that result loads, so no new item is taken meanwhile. Every other
// item goes straight to S_DONE, and the next item follows once S_IDLE is back.
// in_ready is high in the idle state, also while a result waits in the output register.
// Reset (rst_n low, synchronous) clears all mapper state and sets the bank
// count to 2. A stalled output holds the sequencer in its final state.
`timescale 1ns / 1ps

module bank_mapper_with_scanline_irq_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_cmd,
  input  logic [15:0]                   in_bus_addr,
  input  logic [bmsirq_pkg::ByteW-1:0]  in_write_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_mapped,
  output logic [bmsirq_pkg::MaddrW-1:0] out_mapped_addr,
  output logic                          out_irq_line,
  output logic [1:0]                    out_mirror_mode,
  output logic [bmsirq_pkg::ByteW-1:0]  out_ram_protect,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_index,
  input  logic [bmsirq_pkg::ByteW-1:0]  cfg_wdata
);
  import bmsirq_pkg::*;

  localparam int unsigned BankIdxW = $clog2(NumBankRegs);

  // Configuration
  logic [ByteW-1:0] prg_count_r;
  logic             chr_ram_r;
  logic             four_screen_r;

  // Mapper state
  logic [ByteW-1:0] bank_sel_r, bank_sel_nxt;
  logic [ByteW-1:0] bank_regs_r [NumBankRegs];
  logic [ByteW-1:0] bank_regs_nxt [NumBankRegs];
  logic             mirror_r, mirror_nxt;
  logic [ByteW-1:0] protect_r, protect_nxt;
  logic [ByteW-1:0] reload_val_r, reload_val_nxt;
  logic [ByteW-1:0] irq_cnt_r, irq_cnt_nxt;
  logic             reload_pend_r, reload_pend_nxt;
  logic             irq_en_r, irq_en_nxt;
  logic             irq_flag_r, irq_flag_nxt;

  // Sequencer and latched item
  bmsirq_state_t    state_r, state_nxt;
  logic [2:0]       cmd_r;
  logic [15:0]      addr_r;
  logic [ByteW-1:0] data_r;
  logic [ByteW-1:0] bank_rem_r;

  // Output register
  logic              out_valid_r;
  logic              mapped_r, mapped_nxt;
  logic [MaddrW-1:0] maddr_r, maddr_nxt;
  logic              irq_line_r;
  logic [1:0]        mirror_mode_r;
  logic [ByteW-1:0]  ram_prot_r;

  bmsirq_mod_req_t  mod_req;
  bmsirq_mod_sts_t  mod_sts;

  logic             in_fire;
  logic             commit;
  logic [ByteW-1:0] count_eff;
  logic [1:0]       in_win;
  logic [1:0]       win;
  logic [ByteW-1:0] prg_bank;
  logic [12:0]      chr_a;
  logic [ByteW-1:0] chr_reg;
  logic [17:0]      chr_off;
  logic [ByteW-1:0] tick_cnt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign commit    = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign count_eff = (prg_count_r < MinBankCount) ? MinBankCount : prg_count_r;
  assign in_win    = in_bus_addr[14:13];
  assign win       = addr_r[14:13];

  // Start the remainder for CPU reads that use register 6 or 7
  always_comb begin
    mod_req.start    = in_fire && (in_cmd == CMD_CPU_RD) && in_bus_addr[15] &&
                       (in_win != WIN_E000);
    mod_req.dividend = (in_win == WIN_A000) ? bank_regs_r[7] : bank_regs_r[6];
    mod_req.divisor  = count_eff;
  end

  bmsirq_modunit u_modunit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .sts   (mod_sts)
  );

  // Sequence one item through the states
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = mod_req.start ? S_MOD : S_DONE;
      end
      S_MOD: begin
        if (mod_sts.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Map a program window
  always_comb begin
    case (win)
      WIN_8000: prg_bank = bank_sel_r[6] ? count_eff - 8'd2 : bank_rem_r;
      WIN_A000: prg_bank = bank_rem_r;
      WIN_C000: prg_bank = bank_sel_r[6] ? bank_rem_r : count_eff - 8'd2;
      default:  prg_bank = count_eff - 8'd1;
    endcase
  end

  // Map a character window, with the 4K halves optionally swapped
  always_comb begin
    chr_a = addr_r[12:0] ^ {bank_sel_r[7], 12'd0};
    if (!chr_a[12]) begin
      chr_reg = bank_regs_r[BankIdxW'(chr_a[11])];
      chr_off = {chr_reg[ByteW-1:1], chr_a[10:0]};
    end else begin
      chr_reg = bank_regs_r[BankIdxW'(3'd2 + {1'b0, chr_a[11:10]})];
      chr_off = {chr_reg, chr_a[9:0]};
    end
  end

  assign tick_cnt = (irq_cnt_r == '0 || reload_pend_r) ? reload_val_r : irq_cnt_r - 8'd1;

  // Work out the result and the next mapper state
  always_comb begin
    bank_sel_nxt    = bank_sel_r;
    bank_regs_nxt   = bank_regs_r;
    mirror_nxt      = mirror_r;
    protect_nxt     = protect_r;
    reload_val_nxt  = reload_val_r;
    irq_cnt_nxt     = irq_cnt_r;
    reload_pend_nxt = reload_pend_r;
    irq_en_nxt      = irq_en_r;
    irq_flag_nxt    = irq_flag_r;
    mapped_nxt      = 1'b0;
    maddr_nxt       = '0;
    case (cmd_r)
      CMD_CPU_RD: begin
        if (addr_r[15]) begin
          mapped_nxt = 1'b1;
          maddr_nxt  = {prg_bank, addr_r[12:0]};
        end
      end
      CMD_CPU_WR: begin
        if (addr_r[15]) begin
          case (win)
            WIN_8000: begin
              if (!addr_r[0]) bank_sel_nxt = data_r;
              else bank_regs_nxt[bank_sel_r[BankIdxW-1:0]] = data_r;
            end
            WIN_A000: begin
              if (!addr_r[0]) mirror_nxt = data_r[0];
              else protect_nxt = data_r;
            end
            WIN_C000: begin
              if (!addr_r[0]) reload_val_nxt = data_r;
              else reload_pend_nxt = 1'b1;
            end
            default: begin
              if (!addr_r[0]) begin
                irq_en_nxt   = 1'b0;
                irq_flag_nxt = 1'b0;
              end else begin
                irq_en_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      CMD_PPU_RD: begin
        if (addr_r[15:13] == 3'd0) begin
          mapped_nxt = 1'b1;
          maddr_nxt  = chr_ram_r ? MaddrW'(addr_r[12:0]) : MaddrW'(chr_off);
        end
      end
      CMD_PPU_WR: begin
        if (addr_r[15:13] == 3'd0 && chr_ram_r) begin
          mapped_nxt = 1'b1;
          maddr_nxt  = MaddrW'(addr_r[12:0]);
        end
      end
      CMD_TICK: begin
        irq_cnt_nxt     = tick_cnt;
        reload_pend_nxt = 1'b0;
        if (tick_cnt == '0 && irq_en_r) irq_flag_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hold control, configuration and mapper state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      prg_count_r   <= MinBankCount;
      chr_ram_r     <= 1'b0;
      four_screen_r <= 1'b0;
      bank_sel_r    <= '0;
      for (int i = 0; i < NumBankRegs; i++) bank_regs_r[i] <= '0;
      mirror_r      <= 1'b0;
      protect_r     <= '0;
      reload_val_r  <= '0;
      irq_cnt_r     <= '0;
      reload_pend_r <= 1'b0;
      irq_en_r      <= 1'b0;
      irq_flag_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PRG_COUNT:   prg_count_r   <= cfg_wdata;
          CFG_CHR_IS_RAM:  chr_ram_r     <= cfg_wdata[0];
          CFG_FOUR_SCREEN: four_screen_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (commit) begin
        bank_sel_r    <= bank_sel_nxt;
        bank_regs_r   <= bank_regs_nxt;
        mirror_r      <= mirror_nxt;
        protect_r     <= protect_nxt;
        reload_val_r  <= reload_val_nxt;
        irq_cnt_r     <= irq_cnt_nxt;
        reload_pend_r <= reload_pend_nxt;
        irq_en_r      <= irq_en_nxt;
        irq_flag_r    <= irq_flag_nxt;
      end
    end
  end

  // Latch the item, the bank remainder and the result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_cmd;
      addr_r <= in_bus_addr;
      data_r <= in_write_data;
    end
    if (mod_sts.done) bank_rem_r <= mod_sts.rem;
    if (commit) begin
      mapped_r      <= mapped_nxt;
      maddr_r       <= maddr_nxt;
      irq_line_r    <= irq_flag_nxt;
      mirror_mode_r <= four_screen_r ? MIRROR_FOUR : {1'b0, mirror_nxt};
      ram_prot_r    <= protect_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mapped      = mapped_r;
  assign out_mapped_addr = maddr_r;
  assign out_irq_line    = irq_line_r;
  assign out_mirror_mode = mirror_mode_r;
  assign out_ram_protect = ram_prot_r;

endmodule

FILE: sim/bank_mapper_with_scanline_irq_core_test.sv
// Self-checking testbench for bank_mapper_with_scanline_irq_core: predicts every result
// from its own copy of the mapper state and checks each output item against it.
// Depends on bmsirq_pkg and the core RTL.
`timescale 1ns / 1ps

module bank_mapper_with_scanline_irq_core_test;
  import bmsirq_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned PhaseItems    = 63;
  localparam int unsigned StreamItems   = 90;
  localparam int unsigned HoldItems     = 12;
  localparam logic [2:0]  CMD_LAST      = 3'd7;

  typedef struct packed {
    logic              mapped;
    logic [MaddrW-1:0] maddr;
    logic              irq;
    logic [1:0]        mirror;
    logic [ByteW-1:0]  protect;
  } access_result_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  // Block inputs, all known from time zero
  logic             in_valid = 1'b0;
  logic [2:0]       in_cmd = '0;
  logic [15:0]      in_bus_addr = '0;
  logic [ByteW-1:0] in_write_data = '0;
  logic             out_ready = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [ByteW-1:0] cfg_wdata = '0;

  // Block outputs
  logic              in_ready;
  logic              out_valid;
  logic              out_mapped;
  logic [MaddrW-1:0] out_mapped_addr;
  logic              out_irq_line;
  logic [1:0]        out_mirror_mode;
  logic [ByteW-1:0]  out_ram_protect;

  // Test control
  logic        tx_idling = 1'b0;
  logic        rx_idling = 1'b0;
  logic        hold_request = 1'b0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  access_result_t expected_accesses[$];

  // Mapper configuration and state as the predictor sees it
  logic [ByteW-1:0] cfg_bank_count = MinBankCount;
  logic             cfg_chr_ram = 1'b0;
  logic             cfg_four_screen = 1'b0;
  logic [ByteW-1:0] m_bank_select = '0;
  logic [ByteW-1:0] m_bank_regs [NumBankRegs] = '{default: '0};
  logic             m_mirror = 1'b0;
  logic [ByteW-1:0] m_protect = '0;
  logic [ByteW-1:0] m_irq_reload = '0;
  logic [ByteW-1:0] m_irq_count = '0;
  logic             m_reload_pending = 1'b0;
  logic             m_irq_enable = 1'b0;
  logic             m_irq_flag = 1'b0;

  bank_mapper_with_scanline_irq_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_bus_addr     (in_bus_addr),
    .in_write_data   (in_write_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mapped      (out_mapped),
    .out_mapped_addr (out_mapped_addr),
    .out_irq_line    (out_irq_line),
    .out_mirror_mode (out_mirror_mode),
    .out_ram_protect (out_ram_protect),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Advance the mapper state by one bus operation and return its result
  function automatic access_result_t map_access(input logic [2:0] cmd, input logic [15:0] addr,
                                                input logic [7:0] data);
    access_result_t res;
    int unsigned    count;
    int unsigned    r6;
    int unsigned    r7;
    int unsigned    bank;
    int unsigned    ca;
    int unsigned    reg_val;
    res = '0;
    count = (cfg_bank_count < MinBankCount) ? MinBankCount : cfg_bank_count;
    r6 = m_bank_regs[6] % count;
    r7 = m_bank_regs[7] % count;
    case (cmd)
      CMD_CPU_RD: begin
        if (addr[15]) begin
          case (addr[14:13])
            WIN_8000: bank = m_bank_select[6] ? count - 2 : r6;
            WIN_A000: bank = r7;
            WIN_C000: bank = m_bank_select[6] ? r6 : count - 2;
            default:  bank = count - 1;
          endcase
          res.mapped = 1'b1;
          res.maddr = MaddrW'(bank * 32'h2000 + addr[12:0]);
        end
      end
      CMD_CPU_WR: begin
        // Even and odd addresses in each window hit different registers
        if (addr[15]) begin
          case (addr[14:13])
            WIN_8000: begin
              if (!addr[0]) m_bank_select = data;
              else m_bank_regs[m_bank_select[2:0]] = data;
            end
            WIN_A000: begin
              if (!addr[0]) m_mirror = data[0];
              else m_protect = data;
            end
            WIN_C000: begin
              if (!addr[0]) m_irq_reload = data;
              else m_reload_pending = 1'b1;
            end
            default: begin
              if (!addr[0]) begin
                m_irq_enable = 1'b0;
                m_irq_flag = 1'b0;
              end else begin
                m_irq_enable = 1'b1;
              end
            end
          endcase
        end
      end
      CMD_PPU_RD: begin
        if (addr <= 16'h1FFF) begin
          res.mapped = 1'b1;
          if (cfg_chr_ram) begin
            res.maddr = MaddrW'(addr);
          end else begin
            ca = addr[12:0];
            if (m_bank_select[7]) ca = ca ^ 32'h1000;
            if (ca < 32'h1000) begin
              reg_val = m_bank_regs[ca >> 11] & 8'hFE;
              res.maddr = MaddrW'(reg_val * 32'h400 + (ca & 32'h7FF));
            end else begin
              reg_val = m_bank_regs[2 + ((ca - 32'h1000) >> 10)];
              res.maddr = MaddrW'(reg_val * 32'h400 + (ca & 32'h3FF));
            end
          end
        end
      end
      CMD_PPU_WR: begin
        if (addr <= 16'h1FFF && cfg_chr_ram) begin
          res.mapped = 1'b1;
          res.maddr = MaddrW'(addr);
        end
      end
      CMD_TICK: begin
        // Reload on zero or pending reload, else count down
        if (m_irq_count == 0 || m_reload_pending) begin
          m_irq_count = m_irq_reload;
          m_reload_pending = 1'b0;
        end else begin
          m_irq_count = m_irq_count - 8'd1;
        end
        if (m_irq_count == 0 && m_irq_enable) m_irq_flag = 1'b1;
      end
      default: ;
    endcase
    res.irq = m_irq_flag;
    res.mirror = cfg_four_screen ? MIRROR_FOUR : {1'b0, m_mirror};
    res.protect = m_protect;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    error_count++;
  endtask

  // Record configuration writes and predict each accepted item
  always @(posedge clk) begin
    if (rst_n && cfg_wr_en) begin
      case (cfg_index)
        CFG_PRG_COUNT:   cfg_bank_count = cfg_wdata;
        CFG_CHR_IS_RAM:  cfg_chr_ram = cfg_wdata[0];
        CFG_FOUR_SCREEN: cfg_four_screen = cfg_wdata[0];
        default: ;
      endcase
    end
    if (rst_n && in_valid && in_ready)
      expected_accesses.push_back(map_access(in_cmd, in_bus_addr, in_write_data));
  end

  // Compare each output item with the oldest prediction
  always @(posedge clk) begin : check_results
    access_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_accesses.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_mapped_addr), '0);
      end else begin
        want = expected_accesses.pop_front();
        if (out_mapped !== want.mapped) report_mismatch("mapped", 32'(out_mapped), 32'(want.mapped));
        if (out_mapped_addr !== want.maddr)
          report_mismatch("mapped_addr", 32'(out_mapped_addr), 32'(want.maddr));
        if (out_irq_line !== want.irq) report_mismatch("irq_line", 32'(out_irq_line), 32'(want.irq));
        if (out_mirror_mode !== want.mirror)
          report_mismatch("mirror_mode", 32'(out_mirror_mode), 32'(want.mirror));
        if (out_ram_protect !== want.protect)
          report_mismatch("ram_protect", 32'(out_ram_protect), 32'(want.protect));
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item, with an optional idle gap first; return once it is accepted
  task automatic send_access(input logic [2:0] cmd, input logic [15:0] addr,
                             input logic [7:0] data);
    int unsigned gap;
    gap = 0;
    if (tx_idling && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_bus_addr <= addr;
    in_write_data <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    // Let the prediction of the last accepted item land first
    @(posedge clk);
    while (expected_accesses.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_config(input logic [7:0] count, input logic chr_ram, input logic four);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_PRG_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_index <= CFG_CHR_IS_RAM;
    cfg_wdata <= ByteW'(chr_ram);
    @(posedge clk);
    cfg_index <= CFG_FOUR_SCREEN;
    cfg_wdata <= ByteW'(four);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly register writes and in-range accesses, with some stray addresses and commands
  task automatic send_random_access();
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    addr = 16'($urandom_range(0, 16'hFFFF));
    data = 8'($urandom_range(0, 255));
    if (pick < 40) begin
      cmd = CMD_CPU_WR;
      if ($urandom_range(0, 9) != 0) addr[15] = 1'b1;
      // Keep reload values small so the counter reaches zero often
      if (addr[15] && addr[14:13] == WIN_C000 && !addr[0] && $urandom_range(0, 3) != 0)
        data = 8'($urandom_range(0, 7));
    end else if (pick < 65) begin
      cmd = CMD_CPU_RD;
      if ($urandom_range(0, 9) != 0) addr[15] = 1'b1;
    end else if (pick < 82) begin
      cmd = CMD_PPU_RD;
      if ($urandom_range(0, 9) != 0) addr[15:13] = 3'b000;
    end else if (pick < 87) begin
      cmd = CMD_PPU_WR;
      if ($urandom_range(0, 9) != 0) addr[15:13] = 3'b000;
    end else if (pick < 97) begin
      cmd = CMD_TICK;
    end else begin
      cmd = 3'($urandom_range(CMD_TICK + 1, CMD_LAST));
    end
    send_access(cmd, addr, data);
  endtask

  task automatic run_phase(input logic [7:0] count, input logic chr_ram, input logic four,
                           input int unsigned n_items);
    drain_results();
    program_config(count, chr_ram, four);
    repeat (n_items) send_random_access();
  endtask

  // Address and command corners at the reset configuration
  task automatic test_edge_cases();
    send_access(CMD_CPU_RD, 16'h8000, 8'h00);
    send_access(CMD_CPU_RD, 16'hFFFF, 8'hFF);
    send_access(CMD_CPU_RD, 16'h7FFF, 8'h00);
    send_access(CMD_CPU_WR, 16'h7FFF, 8'hFF);
    send_access(CMD_PPU_RD, 16'h0000, 8'h00);
    send_access(CMD_PPU_RD, 16'h2000, 8'h00);
    send_access(CMD_PPU_WR, 16'h1FFF, 8'hFF);
    send_access(CMD_TICK, 16'hFFFF, 8'hFF);
    for (int c = CMD_TICK + 1; c <= CMD_LAST; c++) send_access(3'(c), 16'hFFFF, 8'hFF);
  endtask

  // Bank counts below the minimum, character RAM and four-screen mirroring
  task automatic test_config_specials();
    drain_results();
    program_config(8'd0, 1'b1, 1'b1);
    send_access(CMD_PPU_WR, 16'h1FFF, 8'h00);
    send_access(CMD_PPU_RD, 16'h0ABC, 8'h00);
    send_access(CMD_CPU_RD, 16'hE000, 8'h00);
    drain_results();
    program_config(8'd1, 1'b0, 1'b0);
    send_access(CMD_CPU_RD, 16'hDFFF, 8'h00);
  endtask

  // Every register of the write map, window swap, character inversion and the counter
  task automatic test_register_map();
    drain_results();
    program_config(8'd254, 1'b0, 1'b0);
    send_access(CMD_CPU_WR, 16'h8000, 8'h46);
    send_access(CMD_CPU_WR, 16'h8001, 8'hFF);
    send_access(CMD_CPU_RD, 16'h8000, 8'h00);
    send_access(CMD_CPU_RD, 16'hC000, 8'h00);
    send_access(CMD_CPU_RD, 16'hFFFF, 8'h00);
    send_access(CMD_CPU_WR, 16'h8000, 8'h87);
    send_access(CMD_CPU_WR, 16'h9FFF, 8'hFD);
    send_access(CMD_CPU_RD, 16'hA000, 8'h00);
    send_access(CMD_PPU_RD, 16'h0000, 8'h00);
    send_access(CMD_PPU_RD, 16'h1FFF, 8'h00);
    send_access(CMD_CPU_WR, 16'hA000, 8'h01);
    send_access(CMD_CPU_WR, 16'hBFFF, 8'hFF);
    send_access(CMD_CPU_WR, 16'hC000, 8'h01);
    send_access(CMD_CPU_WR, 16'hC001, 8'h00);
    send_access(CMD_CPU_WR, 16'hE001, 8'h00);
    send_access(CMD_TICK, 16'h0000, 8'h00);
    send_access(CMD_TICK, 16'h0000, 8'h00);
    send_access(CMD_CPU_WR, 16'hE000, 8'h00);
    send_access(CMD_TICK, 16'h0000, 8'h00);
  endtask

  // Random traffic over several configurations, extremes included
  task automatic test_random_traffic();
    run_phase(8'd2, 1'b0, 1'b0, PhaseItems);
    run_phase(8'd254, 1'b0, 1'b1, PhaseItems);
    run_phase(8'd254, 1'b1, 1'b0, PhaseItems);
    run_phase(8'($urandom_range(1, 127) * 2), 1'b0, 1'b0, PhaseItems);
    run_phase(8'($urandom_range(0, 254)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              PhaseItems);
  endtask

  // Hold the result side off for a long stretch while items keep coming
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (HoldItems) send_random_access();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_streaming();
    drain_results();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    program_config(8'($urandom_range(1, 127) * 2), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    repeat (StreamItems) send_random_access();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    test_edge_cases();
    test_config_specials();
    test_register_map();
    test_random_traffic();
    test_output_backpressure();
    test_streaming();
    drain_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bmsirq_pkg.sv
hw/rtl/bmsirq_modunit.sv
hw/rtl/bank_mapper_with_scanline_irq_core.sv
sim/bank_mapper_with_scanline_irq_core_test.sv
